// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the ellipse rasterizer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define MER_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define MER_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication failed");

// Next-cycle implication.
`define MER_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`endif

// ----- hdl/mer_pkg.sv -----
// Package for the midpoint ellipse rasterizer: opcode, region and
// sequencer state types. No dependencies.
package mer_pkg;

  // Input word opcode
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

  // Ellipse progress
  typedef enum logic [1:0] {
    REG_IDLE  = 2'd0,  // nothing loaded or ellipse done
    REG_FIRST = 2'd1,  // first point (0,b) pending
    REG_ONE   = 2'd2,  // region one
    REG_TWO   = 2'd3   // region two
  } region_e;

  // Sequencer states around the shared multiplier
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_A,    // a*a
    ST_LD_B,    // b*b
    ST_LD_END,  // store b*b
    ST_MUL1,    // a2*b or b2*(x+1)
    ST_MUL2,    // a2*y
    ST_CMP,     // region one exit test
    ST_FIRST,   // emit first point
    ST_UPD2,    // region one step
    ST_T0,      // t*t, t = 2x+1
    ST_T1,      // b2*t*t
    ST_T2,      // (y-1)*(y-1)
    ST_T3,      // a2*(y-1)^2
    ST_T4,      // a2*b2
    ST_T5,      // region two start value
    ST_UPD3     // region two step
  } state_e;

endpackage

// ----- hdl/midpoint_ellipse_rasterizer_top.sv -----
// Top level of the midpoint ellipse rasterizer: load, sequencer, shared
// multiplier and output register. Depends on mer_pkg and assert_macros.svh.

// A load word (opcode 0) takes two corners, derives center and semi-axes and
// returns nothing; it occupies the block while a*a and b*b go through the
// shared multiplier. Each step word (opcode 1) returns one word with the four
// mirrored points of the next ellipse point, starting at (0,b); final_step
// marks the point at y offset 0, after which steps return nothing until the
// next load. All products go through one registered COORD_BITS-derived
// multiplier, one product per cycle. The first point passes through MUL1 and
// FIRST, a step inside either region through MUL1, MUL2, CMP and UPD2 or UPD3,
// and the step that crosses from region one to region two through MUL1, MUL2,
// CMP, T0 to T5 and UPD3. A result waiting on a stalled output holds the
// sequencer in its final state.
`include "assert_macros.svh"

module midpoint_ellipse_rasterizer_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] q0_x_o,
  output logic [COORD_BITS-1:0] q0_y_o,
  output logic [COORD_BITS-1:0] q1_x_o,
  output logic [COORD_BITS-1:0] q1_y_o,
  output logic [COORD_BITS-1:0] q2_x_o,
  output logic [COORD_BITS-1:0] q2_y_o,
  output logic [COORD_BITS-1:0] q3_x_o,
  output logic [COORD_BITS-1:0] q3_y_o,
  output logic                  final_step_o
);

  localparam int unsigned SemiBits = COORD_BITS - 1;
  localparam int unsigned SqBits   = 2 * SemiBits;
  localparam int unsigned MulBits  = 2 * COORD_BITS + 2;
  localparam int unsigned ProdBits = 2 * MulBits;
  localparam int unsigned DecBits  = 4 * COORD_BITS;

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  mer_pkg::state_e  state_q, state_d;
  mer_pkg::region_e region_q, region_d;

  logic [COORD_BITS-1:0] offset_x_q, offset_x_d;
  logic [COORD_BITS-1:0] offset_y_q, offset_y_d;
  logic [COORD_BITS-1:0] center_x_q, center_x_d;
  logic [COORD_BITS-1:0] center_y_q, center_y_d;
  logic [SemiBits-1:0]   semi_a_q, semi_a_d;
  logic [SemiBits-1:0]   semi_b_q, semi_b_d;
  logic [SqBits-1:0]     a2_q, a2_d;
  logic [SqBits-1:0]     b2_q, b2_d;
  logic [DecBits-1:0]    decision_q, decision_d;
  logic [DecBits-1:0]    prod_q, prod_d;
  logic [DecBits-1:0]    p1_q, p1_d;     // b2*(x+1)
  logic [DecBits-1:0]    qa_q, qa_d;     // a2*y
  logic [DecBits-1:0]    acc_q, acc_d;
  logic                  stay_q, stay_d; // region one continues

  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] q0_x_q, q0_x_d, q0_y_q, q0_y_d;
  logic [COORD_BITS-1:0] q1_x_q, q1_x_d, q1_y_q, q1_y_d;
  logic [COORD_BITS-1:0] q2_x_q, q2_x_d, q2_y_q, q2_y_d;
  logic [COORD_BITS-1:0] q3_x_q, q3_x_d, q3_y_q, q3_y_d;
  logic                  final_q, final_d;

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  logic in_fire;
  logic is_load;
  logic emit_ok;

  assign in_stall_o = (state_q != mer_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_load    = (mer_pkg::opcode_e'(opcode_i) == mer_pkg::OP_LOAD);
  assign emit_ok    = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------
  // Corner to center / semi-axis, half difference truncated to zero
  // ---------------------------------------------------------------
  logic signed [COORD_BITS:0] diff_x, diff_y, half_x, half_y, mag_x, mag_y;

  always_comb begin
    diff_x = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    diff_y = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    half_x = (diff_x + $signed({{COORD_BITS{1'b0}}, diff_x[COORD_BITS]})) >>> 1;
    half_y = (diff_y + $signed({{COORD_BITS{1'b0}}, diff_y[COORD_BITS]})) >>> 1;
    mag_x  = half_x[COORD_BITS] ? -half_x : half_x;
    mag_y  = half_y[COORD_BITS] ? -half_y : half_y;
  end

  // ---------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------
  logic [MulBits-1:0]    mul_a, mul_b;
  logic [ProdBits-1:0]   mul_full;
  logic                  mul_en;
  logic [COORD_BITS:0]   x_inc;   // x+1
  logic [COORD_BITS:0]   t_odd;   // 2x+1
  logic [COORD_BITS-1:0] y_dec;   // y-1

  assign x_inc = {1'b0, offset_x_q} + {{COORD_BITS{1'b0}}, 1'b1};
  assign t_odd = {offset_x_q, 1'b1};
  assign y_dec = offset_y_q - {{(COORD_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      mer_pkg::ST_LD_A: begin
        mul_a = MulBits'(semi_a_q);
        mul_b = MulBits'(semi_a_q);
      end
      mer_pkg::ST_LD_B: begin
        mul_a = MulBits'(semi_b_q);
        mul_b = MulBits'(semi_b_q);
      end
      mer_pkg::ST_MUL1: begin
        if (region_q == mer_pkg::REG_FIRST) begin
          mul_a = MulBits'(a2_q);
          mul_b = MulBits'(semi_b_q);
        end else begin
          mul_a = MulBits'(b2_q);
          mul_b = MulBits'(x_inc);
        end
      end
      mer_pkg::ST_MUL2: begin
        mul_a = MulBits'(a2_q);
        mul_b = MulBits'(offset_y_q);
      end
      mer_pkg::ST_T0: begin
        mul_a = MulBits'(t_odd);
        mul_b = MulBits'(t_odd);
      end
      mer_pkg::ST_T1: begin
        mul_a = MulBits'(b2_q);
        mul_b = prod_q[MulBits-1:0];
      end
      mer_pkg::ST_T2: begin
        mul_a = MulBits'(y_dec);
        mul_b = MulBits'(y_dec);
      end
      mer_pkg::ST_T3: begin
        mul_a = MulBits'(a2_q);
        mul_b = prod_q[MulBits-1:0];
      end
      mer_pkg::ST_T4: begin
        mul_a = MulBits'(a2_q);
        mul_b = MulBits'(b2_q);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign prod_d   = mul_en ? mul_full[DecBits-1:0] : prod_q;

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_load) begin
            state_d = mer_pkg::ST_LD_A;
          end else if (region_q != mer_pkg::REG_IDLE) begin
            state_d = mer_pkg::ST_MUL1;
          end
        end
      end
      mer_pkg::ST_LD_A:   state_d = mer_pkg::ST_LD_B;
      mer_pkg::ST_LD_B:   state_d = mer_pkg::ST_LD_END;
      mer_pkg::ST_LD_END: state_d = mer_pkg::ST_IDLE;
      mer_pkg::ST_MUL1: begin
        state_d = (region_q == mer_pkg::REG_FIRST) ? mer_pkg::ST_FIRST
                                                   : mer_pkg::ST_MUL2;
      end
      mer_pkg::ST_MUL2: state_d = mer_pkg::ST_CMP;
      mer_pkg::ST_CMP: begin
        if (stay_d) begin
          state_d = mer_pkg::ST_UPD2;
        end else if (region_q == mer_pkg::REG_ONE) begin
          state_d = mer_pkg::ST_T0;
        end else begin
          state_d = mer_pkg::ST_UPD3;
        end
      end
      mer_pkg::ST_T0: state_d = mer_pkg::ST_T1;
      mer_pkg::ST_T1: state_d = mer_pkg::ST_T2;
      mer_pkg::ST_T2: state_d = mer_pkg::ST_T3;
      mer_pkg::ST_T3: state_d = mer_pkg::ST_T4;
      mer_pkg::ST_T4: state_d = mer_pkg::ST_T5;
      mer_pkg::ST_T5: state_d = mer_pkg::ST_UPD3;
      mer_pkg::ST_FIRST, mer_pkg::ST_UPD2, mer_pkg::ST_UPD3: begin
        if (emit_ok) state_d = mer_pkg::ST_IDLE;
      end
      default: state_d = mer_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Datapath and result words
  // ---------------------------------------------------------------
  logic [DecBits-1:0] a2_w, b2_w, p1_x8, qa_x8, a2_x8, a2_x12;
  logic [DecBits-1:0] cmp_lhs, cmp_rhs;
  logic               dec_nonpos;
  logic               emit;

  assign a2_w       = DecBits'(a2_q);
  assign b2_w       = DecBits'(b2_q);
  assign p1_x8      = p1_q << 3;
  assign qa_x8      = qa_q << 3;
  assign a2_x8      = a2_w << 3;
  assign a2_x12     = (a2_w << 3) + (a2_w << 2);
  assign cmp_lhs    = p1_q << 1;
  assign cmp_rhs    = (prod_q << 1) - a2_w;
  assign dec_nonpos = (decision_q == '0) || decision_q[DecBits-1];

  always_comb begin
    region_d    = region_q;
    offset_x_d  = offset_x_q;
    offset_y_d  = offset_y_q;
    center_x_d  = center_x_q;
    center_y_d  = center_y_q;
    semi_a_d    = semi_a_q;
    semi_b_d    = semi_b_q;
    a2_d        = a2_q;
    b2_d        = b2_q;
    decision_d  = decision_q;
    p1_d        = p1_q;
    qa_d        = qa_q;
    acc_d       = acc_q;
    stay_d      = stay_q;
    emit        = 1'b0;

    unique case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_fire && is_load) begin
          center_x_d = start_x_i + half_x[COORD_BITS-1:0];
          center_y_d = start_y_i + half_y[COORD_BITS-1:0];
          semi_a_d   = mag_x[SemiBits-1:0];
          semi_b_d   = mag_y[SemiBits-1:0];
          offset_x_d = '0;
          offset_y_d = COORD_BITS'(mag_y[SemiBits-1:0]);
          decision_d = '0;
          region_d   = mer_pkg::REG_FIRST;
        end
      end
      mer_pkg::ST_LD_B:   a2_d = prod_q[SqBits-1:0];
      mer_pkg::ST_LD_END: b2_d = prod_q[SqBits-1:0];
      mer_pkg::ST_MUL2:   p1_d = prod_q;
      mer_pkg::ST_CMP: begin
        qa_d   = prod_q;
        stay_d = (region_q == mer_pkg::REG_ONE) && (cmp_lhs < cmp_rhs);
      end
      mer_pkg::ST_T2: acc_d = prod_q;
      mer_pkg::ST_T4: acc_d = acc_q + (prod_q << 2);
      mer_pkg::ST_T5: begin
        decision_d = acc_q - (prod_q << 2);
        region_d   = mer_pkg::REG_TWO;
      end
      mer_pkg::ST_FIRST: begin
        if (emit_ok) begin
          emit       = 1'b1;
          decision_d = (b2_w << 2) - (prod_q << 2) + a2_w;
          region_d   = mer_pkg::REG_ONE;
        end
      end
      mer_pkg::ST_UPD2: begin
        if (emit_ok) begin
          emit       = 1'b1;
          offset_x_d = offset_x_q + {{(COORD_BITS-1){1'b0}}, 1'b1};
          if (dec_nonpos) begin
            decision_d = decision_q + p1_x8 + (b2_w << 2);
          end else begin
            decision_d = decision_q + p1_x8 + (b2_w << 2) + a2_x8 - qa_x8;
            offset_y_d = y_dec;
          end
        end
      end
      mer_pkg::ST_UPD3: begin
        if (emit_ok) begin
          emit       = 1'b1;
          offset_y_d = y_dec;
          if (dec_nonpos) begin
            decision_d = decision_q + p1_x8 + a2_x12 - qa_x8;
            offset_x_d = offset_x_q + {{(COORD_BITS-1){1'b0}}, 1'b1};
          end else begin
            decision_d = decision_q + a2_x12 - qa_x8;
          end
        end
      end
      default: ;
    endcase

    // last point ends the ellipse
    if (emit && (offset_y_d == '0)) region_d = mer_pkg::REG_IDLE;
  end

  // result word built from the updated offsets
  always_comb begin
    q0_x_d = q0_x_q;
    q0_y_d = q0_y_q;
    q1_x_d = q1_x_q;
    q1_y_d = q1_y_q;
    q2_x_d = q2_x_q;
    q2_y_d = q2_y_q;
    q3_x_d = q3_x_q;
    q3_y_d = q3_y_q;
    final_d = final_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      q0_x_d  = center_x_q + offset_x_d;
      q0_y_d  = center_y_q + offset_y_d;
      q1_x_d  = center_x_q + offset_x_d;
      q1_y_d  = center_y_q - offset_y_d;
      q2_x_d  = center_x_q - offset_x_d;
      q2_y_d  = center_y_q + offset_y_d;
      q3_x_d  = center_x_q - offset_x_d;
      q3_y_d  = center_y_q - offset_y_d;
      final_d = (offset_y_d == '0);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mer_pkg::ST_IDLE;
      region_q    <= mer_pkg::REG_IDLE;
      out_valid_q <= 1'b0;
      offset_x_q  <= '0;
      offset_y_q  <= '0;
      center_x_q  <= '0;
      center_y_q  <= '0;
      semi_a_q    <= '0;
      semi_b_q    <= '0;
      decision_q  <= '0;
    end else begin
      state_q     <= state_d;
      region_q    <= region_d;
      out_valid_q <= out_valid_d;
      offset_x_q  <= offset_x_d;
      offset_y_q  <= offset_y_d;
      center_x_q  <= center_x_d;
      center_y_q  <= center_y_d;
      semi_a_q    <= semi_a_d;
      semi_b_q    <= semi_b_d;
      decision_q  <= decision_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    a2_q    <= a2_d;
    b2_q    <= b2_d;
    prod_q  <= prod_d;
    p1_q    <= p1_d;
    qa_q    <= qa_d;
    acc_q   <= acc_d;
    stay_q  <= stay_d;
    q0_x_q  <= q0_x_d;
    q0_y_q  <= q0_y_d;
    q1_x_q  <= q1_x_d;
    q1_y_q  <= q1_y_d;
    q2_x_q  <= q2_x_d;
    q2_y_q  <= q2_y_d;
    q3_x_q  <= q3_x_d;
    q3_y_q  <= q3_y_d;
    final_q <= final_d;
  end

  assign out_valid_o  = out_valid_q;
  assign q0_x_o       = q0_x_q;
  assign q0_y_o       = q0_y_q;
  assign q1_x_o       = q1_x_q;
  assign q1_y_o       = q1_y_q;
  assign q2_x_o       = q2_x_q;
  assign q2_y_o       = q2_y_q;
  assign q3_x_o       = q3_x_q;
  assign q3_y_o       = q3_y_q;
  assign final_step_o = final_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  logic in_region;
  logic at_restart;

  assign in_region  = (region_q == mer_pkg::REG_ONE) || (region_q == mer_pkg::REG_TWO);
  assign at_restart = (region_q == mer_pkg::REG_FIRST) && (offset_x_q == '0);

  // a final point lies on the horizontal axis: both y mirrors coincide
  `MER_ASSERT_IMPLY(a_final_on_axis, clk_i, rst_ni, out_valid_o && final_step_o, q0_y_o == q1_y_o)
  // inside either region the y offset never reaches zero
  `MER_ASSERT(a_region_y_nonzero, clk_i, rst_ni, !in_region || (offset_y_q != '0))
  // a load restarts at the first point with x offset zero
  `MER_ASSERT_NEXT(a_load_restart, clk_i, rst_ni, in_fire && is_load, at_restart)

endmodule

// ----- test/tb_midpoint_ellipse_rasterizer_top.sv -----
// Self-checking testbench for midpoint_ellipse_rasterizer_top: random and
// directed load/step words, with a scoreboard that predicts each mirrored point set.
// Depends on mer_pkg and the RTL of the rasterizer top level.
module tb_midpoint_ellipse_rasterizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int unsigned WORD_GOAL  = 900;
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One output word: q[0..7] = q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y
  typedef struct {
    coord_t q[8];
    logic   final_step;
  } ellipse_point_t;

  // Tracks the ellipse the block should be drawing and the points still owed
  class ellipse_tracker;
    mer_pkg::region_e region;
    logic [63:0]      off_x, off_y, decision;
    logic [63:0]      semi_a, semi_b, ctr_x, ctr_y;
    ellipse_point_t   points_due[$];
    int               errors;

    function new();
      region   = mer_pkg::REG_IDLE;
      off_x    = '0;
      off_y    = '0;
      decision = '0;
      semi_a   = '0;
      semi_b   = '0;
      ctr_x    = '0;
      ctr_y    = '0;
      errors   = 0;
    endfunction

    // Center and semi-axis of one coordinate, half-difference truncated toward zero
    function void split_axis(coord_t s, coord_t e, output logic [63:0] ctr,
                             output logic [63:0] semi);
      int diff;
      int half;
      diff = int'(e) - int'(s);
      half = diff / 2;
      ctr  = 64'(int'(s) + half);
      semi = 64'((half < 0) ? -half : half);
    endfunction

    function bit at_or_below_zero(logic [63:0] v);
      return (v == 64'd0) || v[63];
    endfunction

    function bit ellipse_done();
      return region == mer_pkg::REG_IDLE;
    endfunction

    function int owed();
      return points_due.size();
    endfunction

    // Advance the prediction by one accepted input word; 1 when a point is due
    function bit accept_word(mer_pkg::opcode_e op, coord_t sx, coord_t sy,
                             coord_t ex, coord_t ey);
      logic [63:0] a2, b2, x, y, t;
      ellipse_point_t p;
      if (op == mer_pkg::OP_LOAD) begin
        split_axis(sx, ex, ctr_x, semi_a);
        split_axis(sy, ey, ctr_y, semi_b);
        off_x    = '0;
        off_y    = semi_b;
        decision = '0;
        region   = mer_pkg::REG_FIRST;
        return 1'b0;
      end
      if (region == mer_pkg::REG_IDLE) return 1'b0;

      a2 = semi_a * semi_a;
      b2 = semi_b * semi_b;

      if (region == mer_pkg::REG_FIRST) begin
        // first point (0,b): only seed the decision
        decision = 4 * b2 - 4 * a2 * semi_b + a2;
        region   = mer_pkg::REG_ONE;
      end else begin
        x = off_x;
        y = off_y;
        if (region == mer_pkg::REG_ONE && 2 * b2 * (x + 1) < a2 * (2 * y - 1)) begin
          if (at_or_below_zero(decision)) begin
            decision += 4 * b2 * (2 * x + 3);
          end else begin
            decision += 4 * b2 * (2 * x + 3) + 8 * a2 - 8 * a2 * y;
            off_y--;
          end
          off_x++;
        end else begin
          // crossing into region two restarts the decision
          if (region == mer_pkg::REG_ONE) begin
            t = 2 * x + 1;
            decision = b2 * t * t + 4 * a2 * ((y - 1) * (y - 1)) - 4 * a2 * b2;
            region   = mer_pkg::REG_TWO;
          end
          if (at_or_below_zero(decision)) begin
            decision += 4 * b2 * (2 * x + 2) + 12 * a2 - 8 * a2 * y;
            off_x++;
          end else begin
            decision += 12 * a2 - 8 * a2 * y;
          end
          off_y--;
        end
      end

      // mirrored points, sums wrap at the coordinate width
      p.q[0] = coord_t'(ctr_x + off_x);
      p.q[1] = coord_t'(ctr_y + off_y);
      p.q[2] = coord_t'(ctr_x + off_x);
      p.q[3] = coord_t'(ctr_y - off_y);
      p.q[4] = coord_t'(ctr_x - off_x);
      p.q[5] = coord_t'(ctr_y + off_y);
      p.q[6] = coord_t'(ctr_x - off_x);
      p.q[7] = coord_t'(ctr_y - off_y);
      p.final_step = (off_y == 64'd0);
      if (p.final_step) region = mer_pkg::REG_IDLE;
      points_due = {points_due, p};
      return 1'b1;
    endfunction

    // Compare one accepted output word with the oldest point due
    function void check_point(ellipse_point_t got);
      ellipse_point_t want;
      if (points_due.size() == 0) begin
        $display("%0t: unexpected word q0=(%0d,%0d) final=%0d", $time,
                 got.q[0], got.q[1], got.final_step);
        errors++;
        return;
      end
      want = points_due.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (got.q[i] !== want.q[i]) begin
          $display("%0t: q%0d_%s mismatch: expected %0d, got %0d", $time, i / 2,
                   (i % 2) ? "y" : "x", want.q[i], got.q[i]);
          errors++;
        end
      end
      if (got.final_step !== want.final_step) begin
        $display("%0t: final_step mismatch: expected %0d, got %0d", $time,
                 want.final_step, got.final_step);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  logic   opcode_i;
  coord_t start_x_i, start_y_i, end_x_i, end_y_i;
  logic   out_valid_o;
  logic   out_stall_i;
  coord_t q0_x_o, q0_y_o, q1_x_o, q1_y_o, q2_x_o, q2_y_o, q3_x_o, q3_y_o;
  logic   final_step_o;

  ellipse_tracker tracker;
  int unsigned    words_counted;
  bit             no_idle;

  midpoint_ellipse_rasterizer_top #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .q0_x_o      (q0_x_o),
    .q0_y_o      (q0_y_o),
    .q1_x_o      (q1_x_o),
    .q1_y_o      (q1_y_o),
    .q2_x_o      (q2_x_o),
    .q2_y_o      (q2_y_o),
    .q3_x_o      (q3_x_o),
    .q3_y_o      (q3_y_o),
    .final_step_o(final_step_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one input word after a random gap; returns at its acceptance edge
  task automatic send_word(mer_pkg::opcode_e op, coord_t sx, coord_t sy,
                           coord_t ex, coord_t ey);
    int unsigned gap;
    bit          taken;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (tracker.accept_word(op, sx, sy, ex, ey) || op == mer_pkg::OP_LOAD) words_counted++;
  endtask

  // Random coordinate over the full range
  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  // Step word; coordinate fields are don't-care, so they carry noise
  task automatic step_word();
    send_word(mer_pkg::OP_STEP, any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  task automatic run_ellipse(int unsigned cap);
    int unsigned n;
    n = 0;
    while (!tracker.ellipse_done() && n < cap) begin
      step_word();
      n++;
    end
  endtask

  // Coordinate within span of c, clamped to the legal range
  function automatic coord_t near(coord_t c, int span);
    int v;
    v = int'(c) - span + int'($urandom_range(0, 2 * span));
    if (v < 0) v = 0;
    if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
    return coord_t'(v);
  endfunction

  // Output side: random stall before each word, then take it and check it
  initial begin : point_sink
    int unsigned    hold;
    bit             got_word;
    ellipse_point_t got;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got_word = out_valid_o;
        got.q[0] = q0_x_o;
        got.q[1] = q0_y_o;
        got.q[2] = q1_x_o;
        got.q[3] = q1_y_o;
        got.q[4] = q2_x_o;
        got.q[5] = q2_y_o;
        got.q[6] = q3_x_o;
        got.q[7] = q3_y_o;
        got.final_step = final_step_o;
        @(posedge clk_i);
      end while (!got_word);
      tracker.check_point(got);
    end
  end

  // Hang detection: cycles in a row with no word moving on either side
  initial begin : hang_watch
    int unsigned quiet;
    quiet = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    while (quiet < HANG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence: reset, directed words, random ellipses, drain
  initial begin : stimulus
    int unsigned kind;
    int          span;
    coord_t      sx, sy;
    tracker       = new();
    words_counted = 0;
    no_idle       = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    opcode_i    <= mer_pkg::OP_LOAD;
    start_x_i   <= '0;
    start_y_i   <= '0;
    end_x_i     <= '0;
    end_y_i     <= '0;
    out_stall_i <= 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step with nothing loaded
    step_word();
    // largest ellipse, full-scale corners; a few steps into region one
    send_word(mer_pkg::OP_LOAD, '0, '0, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    repeat (3) step_word();
    // reversed corners restart the ellipse mid-way (negative half-differences)
    send_word(mer_pkg::OP_LOAD, coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0, '0);
    repeat (2) step_word();
    // flat ellipse: b is zero, first point is final; then a step while done
    send_word(mer_pkg::OP_LOAD, 12'd100, 12'd50, 12'd111, 12'd51);
    repeat (2) step_word();
    // a is zero: goes straight to region two
    send_word(mer_pkg::OP_LOAD, 12'd10, 12'd10, 12'd11, 12'd20);
    run_ellipse(8);
    // odd, negative differences truncate toward zero; goes straight to region two
    send_word(mer_pkg::OP_LOAD, 12'd3, 12'd7, 12'd0, 12'd0);
    run_ellipse(8);
    step_word();

    // random ellipses, mostly small and run to the end
    while (words_counted < WORD_GOAL) begin
      if ($urandom_range(0, 99) < 12) no_idle = ~no_idle;
      kind = $urandom_range(0, 99);
      sx = any_coord();
      sy = any_coord();
      if (kind < 85) begin
        span = (kind < 75) ? 40 : 200;
        send_word(mer_pkg::OP_LOAD, sx, sy, near(sx, $urandom_range(0, span)),
                  near(sy, $urandom_range(0, span)));
        run_ellipse(1000);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) step_word();
      end else if (kind < 93) begin
        // full-range corners, cut short by the next load
        send_word(mer_pkg::OP_LOAD, sx, sy, any_coord(), any_coord());
        run_ellipse($urandom_range(1, 20));
      end else begin
        // noise: random opcodes and fields
        repeat ($urandom_range(1, 5)) begin
          send_word(mer_pkg::opcode_e'($urandom_range(0, 1)), any_coord(),
                    any_coord(), any_coord(), any_coord());
        end
      end
    end
    in_valid_i <= 1'b0;

    // let the owed points drain, then allow for stray words
    while (tracker.owed() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mer_pkg.sv
hdl/midpoint_ellipse_rasterizer_top.sv
test/tb_midpoint_ellipse_rasterizer_top.sv
